FILE: hw/rtl/is_pkg.sv
// shared types and constants for the insertion sorter
`timescale 1ns / 1ps

package is_pkg;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned DATA_W   = 32;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]         cnt_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic  ins;      // insert value this cycle
    logic  shift;    // move every entry one place toward cell 0
    data_t value;    // value being inserted
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

endpackage

FILE: hw/rtl/is_intf.sv
// valid/ready channel interfaces for input elements and sorted results
`timescale 1ns / 1ps

interface is_in_if import is_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value;
  logic  last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface is_out_if import is_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  last_res;
  logic  overflowed;

  modport source (output valid, output sorted_value, output last_res, output overflowed,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_res, input overflowed,
                  output ready);
endinterface

FILE: hw/rtl/is_cell.sv
// one cell of the sorting chain: holds one entry, compares and shifts
`timescale 1ns / 1ps

module is_cell import is_pkg::*; (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      occ_i,       // entry holds a stored value
  input  logic      tail_i,      // first free place
  input  logic      prev_gt_i,   // lower neighbor is greater than the new value
  input  data_t     prev_val_i,
  input  data_t     next_val_i,
  output data_t     val_o,
  output logic      gt_o
);

  data_t val_q, val_d;

  assign gt_o  = occ_i && (val_q > ctl_i.value);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.ins) begin
      if (prev_gt_i) begin
        val_d = prev_val_i;
      end else if (gt_o || tail_i) begin
        val_d = ctl_i.value;
      end
    end else if (ctl_i.shift) begin
      val_d = next_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

FILE: hw/rtl/insertion_sorter.sv
// insertion sorter: chain of compare/shift cells with fill and drain sequencing
//
//   channel  dir  payload                              transfer when
//   in_i     in   value[31:0] signed, last             in_i.valid && in_i.ready
//   out_o    out  sorted_value[31:0], last_res, ovf    out_o.valid && out_o.ready
//
// while filling, one element is taken every cycle; all cells compare and shift at once
// the element marked last is inserted unless the store is full, then the run drains from cell 0
// at one result per cycle while out_o.ready is high; a run of n elements yields min(n, CAPACITY) results
// input is held off while draining; an output stall simply freezes the chain
// rst_ni clears the count, the overflow flag and the state; cell contents are not reset
`timescale 1ns / 1ps

module insertion_sorter import is_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  is_in_if.sink   in_i,
  is_out_if.source out_o
);

  state_e    state_q, state_d;
  cnt_t      count_q, count_d;
  logic      drop_q, drop_d;
  cell_ctl_t ctl;

  data_t cell_val  [CAPACITY];
  logic  cell_gt   [CAPACITY];
  logic  prev_gt   [CAPACITY];
  data_t prev_val  [CAPACITY];
  data_t next_val  [CAPACITY];
  logic  occ       [CAPACITY];
  logic  tail      [CAPACITY];

  logic in_xfer, out_xfer, full;

  assign in_i.ready = (state_q == ST_FILL);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign full       = (count_q == CNT_W'(CAPACITY));

  assign out_o.valid        = (state_q == ST_DRAIN);
  assign out_o.sorted_value = cell_val[0];
  assign out_o.last_res     = (count_q == CNT_W'(1));
  assign out_o.overflowed   = drop_q;
  assign out_xfer           = out_o.valid && out_o.ready;

  assign ctl.ins   = in_xfer && !full;
  assign ctl.shift = out_xfer;
  assign ctl.value = in_i.value;

  // neighbor wiring; ends of the chain see their own value
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i]      = (CNT_W'(i) < count_q);
      tail[i]     = (CNT_W'(i) == count_q);
      prev_gt[i]  = (i > 0) ? cell_gt[(i > 0) ? i - 1 : 0] : 1'b0;
      prev_val[i] = cell_val[(i > 0) ? i - 1 : 0];
      next_val[i] = cell_val[(i < CAPACITY - 1) ? i + 1 : CAPACITY - 1];
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    is_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .occ_i      (occ[g]),
      .tail_i     (tail[g]),
      .prev_gt_i  (prev_gt[g]),
      .prev_val_i (prev_val[g]),
      .next_val_i (next_val[g]),
      .val_o      (cell_val[g]),
      .gt_o       (cell_gt[g])
    );
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    drop_d  = drop_q;
    case (state_q)
      ST_FILL: begin
        if (in_xfer) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
          if (in_i.last) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (out_xfer) begin
          count_d = count_q - CNT_W'(1);
          if (count_q == CNT_W'(1)) begin
            state_d = ST_FILL;
            drop_d  = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
        count_d = '0;
        drop_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_FILL;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
    end
  end

  // a drained run always has at least one entry left
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |-> (count_q != '0))
    else $error("drain with empty store");

  // input and output never open together
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input and output both active");

  // a last element starts the drain in the next cycle
  a_last_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.last) |=> out_o.valid)
    else $error("last element did not start drain");

  // the count never passes the capacity
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

endmodule
